// ----- src/slot_allocator_with_reuse_delay_macros.svh -----
// Assertion macros used by the slot allocator request sequencer.
`ifndef SLOT_ALLOCATOR_WITH_REUSE_DELAY_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_REUSE_DELAY_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SARD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SARD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/sard_pkg.sv -----
// Shared types and constants for the slot allocator.
package sard_pkg;

   localparam int MAX_SLOTS_DEF = 1024;

   localparam int SLOT_W     = 10;
   localparam int TICK_W     = 32;
   localparam int HW_OUT_W   = 11;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_INDEX    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE_DELAY    = 2'd2;

   // register reset values
   localparam logic [SLOT_W-1:0] FIRST_INDEX_RST    = 10'd1;
   localparam logic [TICK_W-1:0] STARTUP_WINDOW_RST = 32'd2000;
   localparam logic [TICK_W-1:0] REUSE_DELAY_RST    = 32'd500;

   typedef struct packed {
      logic [SLOT_W-1:0] first_index;
      logic [TICK_W-1:0] startup_window;
      logic [TICK_W-1:0] reuse_delay;
   } cfg_type;

   typedef struct packed {
      logic              free_mark;
      logic [TICK_W-1:0] freed_at;
   } slot_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic                reused;
      logic [HW_OUT_W-1:0] high_water_out;
   } result_type;

endpackage

// ----- src/sard_table.sv -----
// Slot table memory: free mark and free tick per slot, one read and one write port.
module sard_table import sard_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   localparam int IDX_W = $clog2(MAX_SLOTS)
) (
   input  logic           clock,
   input  logic           rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output slot_entry_type rd_data,
   input  logic           wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  slot_entry_type wr_data
);

   slot_entry_type mem [MAX_SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sard_ctrl.sv -----
// Request sequencer: clearing sweep, free, first-fit scan and append.
`include "slot_allocator_with_reuse_delay_macros.svh"

module sard_ctrl import sard_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   localparam int IDX_W = $clog2(MAX_SLOTS),
   localparam int HW_W  = $clog2(MAX_SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [TICK_W-1:0] req_now_ticks,
   input  logic [SLOT_W-1:0] req_slot_to_free,
   output logic              res_valid,
   output result_type        res,
   input  logic              res_take,
   output logic              mem_rd_en,
   output logic [IDX_W-1:0]  mem_rd_addr,
   input  slot_entry_type    mem_rd_data,
   output logic              mem_wr_en,
   output logic [IDX_W-1:0]  mem_wr_addr,
   output slot_entry_type    mem_wr_data
);

   localparam int TGT_W = (HW_W > SLOT_W) ? HW_W : SLOT_W;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_APPEND = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_addr_ff, clr_addr_in;
   logic              op_ff, op_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [HW_W-1:0]   hw_ff, hw_in;
   logic [HW_W-1:0]   issue_addr_ff, issue_addr_in;
   logic              data_valid_ff, data_valid_in;
   logic [IDX_W-1:0]  data_addr_ff, data_addr_in;
   result_type        res_ff, res_in;

   logic [TGT_W-1:0]  first_ext, hw_ext, slot_ext, target;
   logic              table_full, issue_more, eligible;
   logic [TICK_W-1:0] age;

   assign first_ext  = TGT_W'(cfg.first_index);
   assign hw_ext     = TGT_W'(hw_ff);
   assign slot_ext   = TGT_W'(slot_ff);
   assign target     = (hw_ext > first_ext) ? hw_ext : first_ext;
   assign table_full = target >= TGT_W'(MAX_SLOTS);
   assign issue_more = issue_addr_ff < hw_ff;

   // wrapping age of the entry that came back from the table
   assign age      = now_ff - mem_rd_data.freed_at;
   assign eligible = mem_rd_data.free_mark &&
                     ((mem_rd_data.freed_at < cfg.startup_window) ||
                      (age > cfg.reuse_delay));

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      slot_in       = slot_ff;
      hw_in         = hw_ff;
      issue_addr_in = issue_addr_ff;
      data_valid_in = 1'b0;
      data_addr_in  = data_addr_ff;
      res_in        = res_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = issue_addr_ff[IDX_W-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = clr_addr_ff;
      mem_wr_data   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(MAX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_type;
               now_in   = req_now_ticks;
               slot_in  = req_slot_to_free;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == REQ_FREE) begin
               res_in.slot_index     = slot_ff;
               res_in.reused         = 1'b0;
               res_in.high_water_out = HW_OUT_W'(hw_ff);
               if (slot_ext >= hw_ext) begin
                  res_in.status = STATUS_BAD_INDEX;
               end else begin
                  res_in.status         = STATUS_OK;
                  mem_wr_en             = 1'b1;
                  mem_wr_addr           = IDX_W'(slot_ff);
                  mem_wr_data.free_mark = 1'b1;
                  mem_wr_data.freed_at  = now_ff;
               end
               state_in = ST_DONE;
            end else if (first_ext < hw_ext) begin
               mem_rd_en     = 1'b1;
               mem_rd_addr   = IDX_W'(cfg.first_index);
               data_valid_in = 1'b1;
               data_addr_in  = IDX_W'(cfg.first_index);
               issue_addr_in = HW_W'(cfg.first_index) + HW_W'(1);
               state_in      = ST_SCAN;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_SCAN: begin
            if (issue_more) begin
               mem_rd_en     = 1'b1;
               data_valid_in = 1'b1;
               data_addr_in  = issue_addr_ff[IDX_W-1:0];
               issue_addr_in = issue_addr_ff + HW_W'(1);
            end
            if (data_valid_ff) begin
               if (eligible) begin
                  mem_wr_en             = 1'b1;
                  mem_wr_addr           = data_addr_ff;
                  mem_wr_data.free_mark = 1'b0;
                  mem_wr_data.freed_at  = mem_rd_data.freed_at;
                  res_in.status         = STATUS_OK;
                  res_in.slot_index     = SLOT_W'(data_addr_ff);
                  res_in.reused         = 1'b1;
                  res_in.high_water_out = HW_OUT_W'(hw_ff);
                  data_valid_in         = 1'b0;
                  state_in              = ST_DONE;
               end else if (!issue_more) begin
                  data_valid_in = 1'b0;
                  state_in      = ST_APPEND;
               end
            end
         end
         ST_APPEND: begin
            res_in.reused = 1'b0;
            if (table_full) begin
               res_in.status         = STATUS_FULL;
               res_in.slot_index     = '0;
               res_in.high_water_out = HW_OUT_W'(hw_ff);
            end else begin
               mem_wr_en             = 1'b1;
               mem_wr_addr           = target[IDX_W-1:0];
               mem_wr_data.free_mark = 1'b0;
               mem_wr_data.freed_at  = now_ff;
               hw_in                 = HW_W'(target + TGT_W'(1));
               res_in.status         = STATUS_OK;
               res_in.slot_index     = SLOT_W'(target);
               res_in.high_water_out = HW_OUT_W'(target + TGT_W'(1));
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         hw_ff         <= '0;
         data_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         hw_ff         <= hw_in;
         data_valid_ff <= data_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      now_ff        <= now_in;
      slot_ff       <= slot_in;
      issue_addr_ff <= issue_addr_in;
      data_addr_ff  <= data_addr_in;
      res_ff        <= res_in;
   end

   `SARD_ASSERT_IMPL(a_hw_bound, clock, reset, 1'b1, hw_ff <= HW_W'(MAX_SLOTS), "high water past table size")
   `SARD_ASSERT_NEXT(a_hw_monotonic, clock, reset, 1'b1, hw_ff >= $past(hw_ff), "high water went down")
   `SARD_ASSERT_IMPL(a_scan_hit_clears, clock, reset, mem_wr_en && (state_ff == ST_SCAN), !mem_wr_data.free_mark, "reused slot left marked free")
   `SARD_ASSERT_NEXT(a_write_ends_request, clock, reset, mem_wr_en && (state_ff != ST_CLEAR), state_ff == ST_DONE, "table write outside request end")

endmodule

// ----- src/slot_allocator_with_reuse_delay.sv -----
// Top level of the first-fit slot allocator with reuse delay.
//
// Hands out slot indexes from a table of MAX_SLOTS entries and takes them
// back. An allocate request walks the table upward from first_index to the
// high-water mark and takes the first slot that is marked free and was either
// freed before startup_window or has aged (wrapping tick difference) beyond
// reuse_delay; if none qualifies the slot at the high-water mark (or at
// first_index, whichever is higher) is appended, or status reports a full
// table. A free request below the high-water mark marks the slot free and
// stamps it with now_ticks; one at or above it returns the bad-index status.
// Every request gives exactly one result. After reset the table is swept
// clear, one entry per cycle, with req_stall high. A free request goes
// through the execute state to the done state. An allocate request reads
// one table entry per cycle during its scan, through the single table read
// port, and if no slot qualifies goes on to the append state before the
// done state. One request is in work at a time; the result sits in an
// output register, so the next request is accepted while an earlier result
// is still stalled at the output.
// Configuration registers may be written only while no request is in flight.
module slot_allocator_with_reuse_delay import sard_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [TICK_W-1:0]     req_now_ticks,
   input  logic [SLOT_W-1:0]     req_slot_to_free,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic                  rsp_reused,
   output logic [HW_OUT_W-1:0]   rsp_high_water_out,
   // register write port
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(MAX_SLOTS);

   cfg_type        cfg_ff, cfg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_ff, rsp_in;

   logic           res_valid, res_take;
   result_type     res;
   logic           mem_rd_en, mem_wr_en;
   logic [IDX_W-1:0] mem_rd_addr, mem_wr_addr;
   slot_entry_type mem_rd_data, mem_wr_data;

   // configuration registers; writes to unused indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FIRST_INDEX:    cfg_in.first_index    = csr_write_data[SLOT_W-1:0];
            CSR_STARTUP_WINDOW: cfg_in.startup_window = csr_write_data[TICK_W-1:0];
            CSR_REUSE_DELAY:    cfg_in.reuse_delay    = csr_write_data[TICK_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_index    <= FIRST_INDEX_RST;
         cfg_ff.startup_window <= STARTUP_WINDOW_RST;
         cfg_ff.reuse_delay    <= REUSE_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // output register: loads when empty or when the result it holds is taken this cycle
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_take) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_slot_index     = rsp_ff.slot_index;
   assign rsp_reused         = rsp_ff.reused;
   assign rsp_high_water_out = rsp_ff.high_water_out;

   sard_ctrl #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_now_ticks    (req_now_ticks),
      .req_slot_to_free (req_slot_to_free),
      .res_valid        (res_valid),
      .res              (res),
      .res_take         (res_take),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data)
   );

   sard_table #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_table (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule
